/* hdl/atr_pkg.sv */
package atr_pkg;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TOGGLE = 1'b1
   } opcode_type;

   localparam int unsigned OFFSET_BITS   = 12;
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 12'd775;

   localparam int unsigned TEMP_BITS     = 11;
   localparam int unsigned RSP_DATA_BITS = 16;
   localparam int          TEMP_MAX      = 1023;
   localparam int          TEMP_MIN_MAG  = 1024;

   localparam logic signed [TEMP_BITS-1:0] TEMP_MAX_CODE = 11'sd1023;
   localparam logic signed [TEMP_BITS-1:0] TEMP_MIN_CODE = -11'sd1024;

endpackage

/* hdl/averaged_temperature_readout_unit.sv */
// Channel  Dir  Ports                     Payload
// req      in   req_tvalid/tready/tdata   tdata: sample_code; tuser: opcode
//                req_tuser
// rsp      out  rsp_tvalid/tready/tdata   tdata: temperature; tuser: in_fahrenheit
//                rsp_tuser
// csr      in   csr_wen/csr_wdata         offset_code, written when csr_wen is high
//
// One word accepted per cycle while req_tready is high. A sample's result is
// registered in turn: the sum is registered at the accepting edge, then
// numerator, reciprocal multiply, correction into the output register.
// A button press updates the scale only and makes no word.
// Synchronous reset clears the window, the sum, the scale and the pipeline.
// Each stage holds while the one after it is full and stalled, so input is
// still taken while a result waits on rsp until all stages are full.
module averaged_temperature_readout_unit #(
   parameter int DEPTH       = 10,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [SAMPLE_BITS-1:0] sample_code, rest zero
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // [0] opcode
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [10:0] temperature (two's complement), rest zero
   output logic [atr_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // [0] in_fahrenheit
   output logic                                   rsp_tuser,
   input  logic                                   csr_wen,
   input  logic [atr_pkg::OFFSET_BITS-1:0]        csr_wdata
);

   localparam int SUM_W = SAMPLE_BITS + 1 + $clog2(DEPTH);
   localparam int NUM_W = SUM_W + 5;
   localparam int MAG_W = SUM_W + 4;
   localparam int TW    = atr_pkg::TEMP_BITS;

   localparam int DIV_C  = 10 * DEPTH;
   localparam int DIV_F  = 50 * DEPTH;
   localparam int F_BIAS = 1600 * DEPTH;

   // floor(2^MAG_W / D): estimate is low by at most one for any magnitude
   localparam longint unsigned RECIP_C = (64'd1 << MAG_W) / DIV_C;
   localparam longint unsigned RECIP_F = (64'd1 << MAG_W) / DIV_F;

   // ---------------- configuration ----------------
   logic [atr_pkg::OFFSET_BITS-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= atr_pkg::OFFSET_RESET;
      end else if (csr_wen) begin
         offset_ff <= csr_wdata;
      end
   end

   logic [SAMPLE_BITS+atr_pkg::OFFSET_BITS-1:0] offset_wide;
   logic [SAMPLE_BITS-1:0]                      offset_m;

   assign offset_wide = {{SAMPLE_BITS{1'b0}}, offset_ff};
   assign offset_m    = offset_wide[SAMPLE_BITS-1:0];

   // ---------------- handshake chain ----------------
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, rsp_valid_ff;
   logic out_rdy, p3_rdy, p2_rdy, p1_rdy;

   assign out_rdy    = !rsp_valid_ff || rsp_tready;
   assign p3_rdy     = !p3_valid_ff || out_rdy;
   assign p2_rdy     = !p2_valid_ff || p3_rdy;
   assign p1_rdy     = !p1_valid_ff || p2_rdy;
   assign req_tready = p1_rdy;

   logic req_accept, is_toggle, take_sample;

   assign req_accept  = req_tvalid && req_tready;
   assign is_toggle   = (atr_pkg::opcode_type'(req_tuser) == atr_pkg::OP_TOGGLE);
   assign take_sample = req_accept && !is_toggle;

   // ---------------- window state ----------------
   // oldest reading always sits in the last tap of the shift line
   logic signed [SAMPLE_BITS:0]  ring_ff [DEPTH];
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic                         mode_ff;
   logic signed [SAMPLE_BITS:0]  reading;

   assign reading = $signed({1'b0, req_tdata[SAMPLE_BITS-1:0]}) - $signed({1'b0, offset_m});
   assign sum_in  = sum_ff - SUM_W'(ring_ff[DEPTH-1]) + SUM_W'(reading);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) ring_ff[i] <= '0;
         sum_ff  <= '0;
         mode_ff <= 1'b0;
      end else if (req_accept) begin
         if (is_toggle) begin
            mode_ff <= !mode_ff;
         end else begin
            ring_ff[0] <= reading;
            for (int i = 1; i < DEPTH; i++) ring_ff[i] <= ring_ff[i-1];
            sum_ff <= sum_in;
         end
      end
   end

   // ---------------- stage 1: window sum ----------------
   logic signed [SUM_W-1:0] p1_sum_ff;
   logic                    p1_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_rdy) begin
         p1_valid_ff <= take_sample;
      end
      if (p1_rdy && take_sample) begin
         p1_sum_ff  <= sum_in;
         p1_mode_ff <= mode_ff;
      end
   end

   // ---------------- stage 2: numerator, sign and magnitude ----------------
   logic signed [NUM_W-1:0] sum_ext, num;
   logic                    num_neg;
   logic [MAG_W-1:0]        num_mag;

   assign sum_ext = NUM_W'(p1_sum_ff);
   // Fahrenheit: 9*S + 1600*DEPTH over 50*DEPTH
   assign num     = p1_mode_ff ? ((sum_ext <<< 3) + sum_ext + NUM_W'(F_BIAS)) : sum_ext;
   assign num_neg = num[NUM_W-1];
   assign num_mag = num_neg ? MAG_W'(-num) : MAG_W'(num);

   logic [MAG_W-1:0] p2_mag_ff;
   logic             p2_neg_ff, p2_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_rdy) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (p2_rdy && p1_valid_ff) begin
         p2_mag_ff  <= num_mag;
         p2_neg_ff  <= num_neg;
         p2_mode_ff <= p1_mode_ff;
      end
   end

   // ---------------- stage 3: reciprocal multiply ----------------
   logic [MAG_W-1:0]   recip_sel;
   logic [2*MAG_W-1:0] recip_prod;

   assign recip_sel  = p2_mode_ff ? MAG_W'(RECIP_F) : MAG_W'(RECIP_C);
   assign recip_prod = (2*MAG_W)'(p2_mag_ff) * (2*MAG_W)'(recip_sel);

   logic [MAG_W-1:0] p3_q_ff, p3_mag_ff;
   logic             p3_neg_ff, p3_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (p3_rdy) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (p3_rdy && p2_valid_ff) begin
         p3_q_ff    <= recip_prod[2*MAG_W-1:MAG_W];
         p3_mag_ff  <= p2_mag_ff;
         p3_neg_ff  <= p2_neg_ff;
         p3_mode_ff <= p2_mode_ff;
      end
   end

   // ---------------- stage 4: correction, sign, saturation ----------------
   logic [MAG_W-1:0]     div_sel, rem, q_fix;
   logic [2*MAG_W-1:0]   qd_full;
   logic signed [TW-1:0] temp_in;

   assign div_sel = p3_mode_ff ? MAG_W'(DIV_F) : MAG_W'(DIV_C);
   assign qd_full = (2*MAG_W)'(p3_q_ff) * (2*MAG_W)'(div_sel);
   assign rem     = p3_mag_ff - qd_full[MAG_W-1:0];
   assign q_fix   = p3_q_ff + MAG_W'(rem >= div_sel);

   always_comb begin
      if (!p3_neg_ff) begin
         temp_in = (q_fix > MAG_W'(atr_pkg::TEMP_MAX)) ? atr_pkg::TEMP_MAX_CODE
                                                       : q_fix[TW-1:0];
      end else begin
         // a magnitude of exactly 1024 negates onto the minimum code
         temp_in = (q_fix > MAG_W'(atr_pkg::TEMP_MIN_MAG)) ? atr_pkg::TEMP_MIN_CODE
                                                           : -q_fix[TW-1:0];
      end
   end

   logic signed [TW-1:0] temp_ff;
   logic                 fahr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= p3_valid_ff;
      end
      if (out_rdy && p3_valid_ff) begin
         temp_ff <= temp_in;
         fahr_ff <= p3_mode_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(atr_pkg::RSP_DATA_BITS-TW){1'b0}}, temp_ff};
   assign rsp_tuser  = fahr_ff;

   // ---------------- assertions ----------------
   a_toggle_keeps_sum: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_toggle) |=> $stable(sum_ff))
      else $error("button press altered the window sum");

   a_toggle_flips_mode: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_toggle) |=> (mode_ff != $past(mode_ff)))
      else $error("button press did not flip the scale");

   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> p1_valid_ff)
      else $error("accepted sample did not enter the pipeline");

   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      p3_valid_ff |-> (rem < (div_sel << 1)))
      else $error("reciprocal estimate off by more than one");

endmodule
